[rtl/core/life_grid_generation_step_core_assert.svh]
// assertion macros for the grid core
// the including module provides clk and rst_n
`ifndef LIFE_GRID_GENERATION_STEP_CORE_ASSERT_SVH
`define LIFE_GRID_GENERATION_STEP_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LGS_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define LGS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/lgs_pkg.sv]
`timescale 1ns / 1ps

package lgs_pkg;

    // field widths of the stream and register beats
    localparam int ACT_W     = 2;
    localparam int ROW_IDX_W = 6;
    localparam int CELLS_W   = 64;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 1;

    // register reset value for width and height
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd30;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

    // neighbor counts for the life rule
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    // item actions
    typedef enum logic [ACT_W-1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_STEP  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

endpackage

[rtl/core/life_grid_generation_step_core.sv]
`timescale 1ns / 1ps

// channel   dir   beat contents
// s_*       in    tuser: action; tdata: row_index, row_cells
// m_*       out   tuser: step_done; tdata: read_cells
// cfg_*     in    register write, index 0 grid_width, index 1 grid_height
//
// after reset a clearing pass writes zero to all MAX_H rows
// a read uses S_READ, an advance S_ADV_PREV, S_ADV_FIRST, S_ADV_ROW
// the advance rate is set by the grid memory ports, one read and one write:
// one row per cycle through the shared row unit
// a result waits in the output register; the next item is taken meanwhile
module life_grid_generation_step_core #(
    parameter int MAX_W = 64,
    parameter int MAX_H = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [71:0]                    s_tdata,   // row_index, row_cells
    input  logic [lgs_pkg::ACT_W-1:0]      s_tuser,   // action
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lgs_pkg::CELLS_W-1:0]    m_tdata,   // read_cells
    output logic                           m_tuser,   // step_done
    input  logic                           cfg_we,
    input  logic [lgs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lgs_pkg::CFG_W-1:0]      cfg_data
);

    import lgs_pkg::*;

`include "life_grid_generation_step_core_assert.svh"

    localparam int ROW_W  = $clog2(MAX_H);
    localparam int COL_W  = (MAX_W > 1) ? $clog2(MAX_W) : 1;
    localparam int WCNT_W = $clog2(MAX_W + 1);
    localparam int HCNT_W = $clog2(MAX_H + 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(MAX_H - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_ADV_PREV,
        S_ADV_FIRST,
        S_ADV_ROW,
        S_RESULT
    } state_t;

    state_t             state_reg, state_next;
    logic [ROW_W-1:0]   row_cnt_reg, row_cnt_next;
    logic [MAX_W-1:0]   prev_reg, prev_next;
    logic [MAX_W-1:0]   cur_reg, cur_next;
    logic [MAX_W-1:0]   first_reg, first_next;
    logic [MAX_W-1:0]   res_cells_reg, res_cells_next;
    logic               res_done_reg, res_done_next;
    logic               row_ok_reg, row_ok_next;
    logic               out_valid_reg, out_valid_next;
    logic [MAX_W-1:0]   out_cells_reg, out_cells_next;
    logic               out_done_reg, out_done_next;
    logic [CFG_W-1:0]   width_reg, height_reg;

    logic [WCNT_W-1:0]  eff_w;
    logic [HCNT_W-1:0]  eff_h;
    logic [COL_W-1:0]   last_col;
    logic [ROW_W-1:0]   last_row;
    logic [MAX_W-1:0]   col_mask;
    logic [MAX_W-1:0]   below;
    logic [MAX_W-1:0]   unit_row;

    action_t            in_action;
    logic [ROW_IDX_W-1:0] in_row;
    logic [CELLS_W-1:0] in_cells;
    logic               in_row_ok;

    logic               mem_wr_en;
    logic [ROW_W-1:0]   mem_wr_addr;
    logic [MAX_W-1:0]   mem_wr_data;
    logic [ROW_W-1:0]   mem_rd_addr;
    logic [MAX_W-1:0]   mem_rd_data;

    // unpack the input beat
    assign in_action = action_t'(s_tuser);
    assign in_row    = s_tdata[ROW_IDX_W-1:0];
    assign in_cells  = s_tdata[ROW_IDX_W +: CELLS_W];

    // clamp width and height to the usable range
    always_comb
    begin
        if (width_reg == '0)
            eff_w = WCNT_W'(1);
        else if (int'(width_reg) > MAX_W)
            eff_w = WCNT_W'(MAX_W);
        else
            eff_w = WCNT_W'(width_reg);
        if (height_reg == '0)
            eff_h = HCNT_W'(1);
        else if (int'(height_reg) > MAX_H)
            eff_h = HCNT_W'(MAX_H);
        else
            eff_h = HCNT_W'(height_reg);
    end

    assign last_col  = COL_W'(eff_w - WCNT_W'(1));
    assign last_row  = ROW_W'(eff_h - HCNT_W'(1));
    assign in_row_ok = int'(in_row) < int'(eff_h);

    // columns in use
    always_comb
    begin
        for (int x = 0; x < MAX_W; x++)
        begin
            col_mask[x] = x < int'(eff_w);
        end
    end

    // row below wraps to the saved first row at the bottom
    assign below = (row_cnt_reg == last_row) ? first_reg : (mem_rd_data & col_mask);

    lgs_grid_mem #(
        .MAX_W (MAX_W),
        .MAX_H (MAX_H),
        .ROW_W (ROW_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    lgs_row_unit #(
        .MAX_W (MAX_W),
        .COL_W (COL_W)
    ) u_row (
        .above    (prev_reg),
        .cur      (cur_reg),
        .below    (below),
        .last_col (last_col),
        .col_mask (col_mask),
        .next_row (unit_row)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        row_cnt_next   = row_cnt_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        first_next     = first_reg;
        res_cells_next = res_cells_reg;
        res_done_next  = res_done_reg;
        row_ok_next    = row_ok_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_cells_next = out_cells_reg;
        out_done_next  = out_done_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = row_cnt_reg;
        mem_wr_data    = '0;
        mem_rd_addr    = row_cnt_reg;

        case (state_reg)
            S_CLEAR:
            begin
                mem_wr_en = 1'b1;
                if (row_cnt_reg == ROW_LAST)
                begin
                    row_cnt_next = '0;
                    state_next   = S_IDLE;
                end
                else
                begin
                    row_cnt_next = row_cnt_reg + ROW_W'(1);
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    res_cells_next = '0;
                    res_done_next  = 1'b0;
                    case (in_action)
                        ACT_WRITE:
                        begin
                            mem_wr_en   = in_row_ok;
                            mem_wr_addr = ROW_W'(in_row);
                            mem_wr_data = in_cells[MAX_W-1:0] & col_mask;
                            state_next  = S_RESULT;
                        end
                        ACT_READ:
                        begin
                            mem_rd_addr = ROW_W'(in_row);
                            row_ok_next = in_row_ok;
                            state_next  = S_READ;
                        end
                        ACT_STEP:
                        begin
                            mem_rd_addr = last_row;
                            state_next  = S_ADV_PREV;
                        end
                        default:
                        begin
                            state_next = S_RESULT;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                res_cells_next = row_ok_reg ? (mem_rd_data & col_mask) : '0;
                state_next     = S_RESULT;
            end
            S_ADV_PREV:
            begin
                // old bottom row is the row above row 0
                prev_next   = mem_rd_data & col_mask;
                mem_rd_addr = '0;
                state_next  = S_ADV_FIRST;
            end
            S_ADV_FIRST:
            begin
                first_next   = mem_rd_data & col_mask;
                cur_next     = mem_rd_data & col_mask;
                row_cnt_next = '0;
                mem_rd_addr  = ROW_W'(1);
                state_next   = S_ADV_ROW;
            end
            S_ADV_ROW:
            begin
                // one row per cycle, fetch two rows ahead
                mem_wr_en   = 1'b1;
                mem_wr_addr = row_cnt_reg;
                mem_wr_data = unit_row;
                prev_next   = cur_reg;
                cur_next    = below;
                mem_rd_addr = row_cnt_reg + ROW_W'(2);
                if (row_cnt_reg == last_row)
                begin
                    res_done_next = 1'b1;
                    state_next    = S_RESULT;
                end
                else
                begin
                    row_cnt_next = row_cnt_reg + ROW_W'(1);
                end
            end
            S_RESULT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_cells_next = res_cells_reg;
                    out_done_next  = res_done_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            row_cnt_reg   <= '0;
            prev_reg      <= '0;
            cur_reg       <= '0;
            first_reg     <= '0;
            res_cells_reg <= '0;
            res_done_reg  <= 1'b0;
            row_ok_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            out_cells_reg <= '0;
            out_done_reg  <= 1'b0;
            width_reg     <= CFG_RESET;
            height_reg    <= CFG_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            row_cnt_reg   <= row_cnt_next;
            prev_reg      <= prev_next;
            cur_reg       <= cur_next;
            first_reg     <= first_next;
            res_cells_reg <= res_cells_next;
            res_done_reg  <= res_done_next;
            row_ok_reg    <= row_ok_next;
            out_valid_reg <= out_valid_next;
            out_cells_reg <= out_cells_next;
            out_done_reg  <= out_done_next;
            if (cfg_we && (cfg_index == CFG_IDX_WIDTH))
            begin
                width_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == CFG_IDX_HEIGHT))
            begin
                height_reg <= cfg_data;
            end
        end
    end

    // ports
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = CELLS_W'(out_cells_reg);
    assign m_tuser  = out_done_reg;

    // checks
    `LGS_ASSERT_HOLDS(a_wr_in_height, mem_wr_en && (state_reg != S_CLEAR), int'(mem_wr_addr) < int'(eff_h), "grid write beyond height")
    `LGS_ASSERT_HOLDS(a_done_no_cells, m_tvalid && m_tuser, m_tdata == '0, "advance result carries cells")
    `LGS_ASSERT_HOLDS(a_out_from_result, $rose(m_tvalid), $past(state_reg) == S_RESULT, "result beat not from result state")
    `LGS_ASSERT_HOLDS(a_adv_row_range, state_reg == S_ADV_ROW, row_cnt_reg <= last_row, "advance row past height")

endmodule

[rtl/core/lgs_grid_mem.sv]
`timescale 1ns / 1ps

module lgs_grid_mem #(
    parameter int MAX_W = 64,
    parameter int MAX_H = 64,
    parameter int ROW_W = 6
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [ROW_W-1:0] wr_addr,
    input  logic [MAX_W-1:0] wr_data,
    input  logic [ROW_W-1:0] rd_addr,
    output logic [MAX_W-1:0] rd_data
);

    logic [MAX_W-1:0] mem_array [MAX_H];
    logic [MAX_W-1:0] rd_data_reg;

    // one write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    // one registered read port
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_array[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/lgs_row_unit.sv]
`timescale 1ns / 1ps

module lgs_row_unit #(
    parameter int MAX_W = 64,
    parameter int COL_W = 6
) (
    input  logic [MAX_W-1:0] above,
    input  logic [MAX_W-1:0] cur,
    input  logic [MAX_W-1:0] below,
    input  logic [COL_W-1:0] last_col,
    input  logic [MAX_W-1:0] col_mask,
    output logic [MAX_W-1:0] next_row
);

    import lgs_pkg::*;

    logic [MAX_W-1:0] alive;

    // one lane per column, wrap at the last column in use
    always_comb
    begin
        logic [7:0] nbr;
        logic [3:0] cnt;
        logic       al, ac, bl, bc, br, ml, mr;
        alive = '0;
        for (int x = 0; x < MAX_W; x++)
        begin
            if (x == 0)
            begin
                al = above[last_col];
                ml = cur[last_col];
                bl = below[last_col];
            end
            else
            begin
                al = above[x-1];
                ml = cur[x-1];
                bl = below[x-1];
            end
            if (COL_W'(x) == last_col)
            begin
                ac = above[0];
                mr = cur[0];
                br = below[0];
            end
            else if (x + 1 < MAX_W)
            begin
                ac = above[(x+1) % MAX_W];
                mr = cur[(x+1) % MAX_W];
                br = below[(x+1) % MAX_W];
            end
            else
            begin
                ac = 1'b0;
                mr = 1'b0;
                br = 1'b0;
            end
            bc  = below[x];
            nbr = {al, above[x], ac, ml, mr, bl, bc, br};
            cnt = 4'($countones(nbr));
            alive[x] = (cnt == BIRTH_COUNT) || ((cnt == SURVIVE_COUNT) && cur[x]);
        end
    end

    assign next_row = alive & col_mask;

endmodule

[bench/tb_life_grid_generation_step_core.sv]
`timescale 1ns / 1ps

module tb_life_grid_generation_step_core;
    import lgs_pkg::*;

    localparam int GRID_MAX_W  = 64;
    localparam int GRID_MAX_H  = 64;
    localparam int NUM_PHASES  = 12;
    localparam int PHASE_ITEMS = 90;
    localparam int LONG_HOLD   = 400;

    // one expected output beat
    typedef struct packed {
        logic [CELLS_W-1:0] read_cells;
        logic               step_done;
    } grid_result_t;

    // tracks the grid contents and holds the results still owed by the block
    class grid_tracker;
        logic [CELLS_W-1:0] rows [GRID_MAX_H];
        logic [CELLS_W-1:0] first_row;
        logic [CELLS_W-1:0] prev_row;
        logic [CFG_W-1:0]   width_reg;
        logic [CFG_W-1:0]   height_reg;
        grid_result_t       owed_results [$];
        int                 errors;

        function new();
            foreach (rows[i])
                rows[i] = '0;
            first_row  = '0;
            prev_row   = '0;
            width_reg  = CFG_RESET;
            height_reg = CFG_RESET;
            errors     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == CFG_IDX_WIDTH)
                width_reg = val;
            else
                height_reg = val;
        endfunction

        // register values clamped into 1..max
        function int eff_width();
            if (width_reg == 0)
                return 1;
            if (width_reg > GRID_MAX_W)
                return GRID_MAX_W;
            return int'(width_reg);
        endfunction

        function int eff_height();
            if (height_reg == 0)
                return 1;
            if (height_reg > GRID_MAX_H)
                return GRID_MAX_H;
            return int'(height_reg);
        endfunction

        function logic [CELLS_W-1:0] col_mask(int w);
            if (w >= CELLS_W)
                return '1;
            return (64'd1 << w) - 64'd1;
        endfunction

        // life rule for one row, columns wrap at w
        function logic [CELLS_W-1:0] next_gen_row(logic [CELLS_W-1:0] above,
                                                  logic [CELLS_W-1:0] cur,
                                                  logic [CELLS_W-1:0] below, int w);
            logic [CELLS_W-1:0] nxt;
            int xl;
            int xr;
            int n;
            nxt = '0;
            for (int x = 0; x < w; x++)
            begin
                xl = (x + w - 1) % w;
                xr = (x + 1) % w;
                n = 0;
                n += above[xl]; n += above[x]; n += above[xr];
                n += cur[xl];   n += cur[xr];
                n += below[xl]; n += below[x]; n += below[xr];
                if (n == BIRTH_COUNT || (n == SURVIVE_COUNT && cur[x]))
                    nxt[x] = 1'b1;
            end
            return nxt;
        endfunction

        // one generation, every row from the old grid
        function void advance_grid();
            int h;
            int w;
            logic [CELLS_W-1:0] m;
            logic [CELLS_W-1:0] cur;
            logic [CELLS_W-1:0] below;
            h = eff_height();
            w = eff_width();
            m = col_mask(w);
            first_row = rows[0] & m;
            prev_row  = rows[h-1] & m;
            for (int y = 0; y < h; y++)
            begin
                cur   = rows[y] & m;
                below = (y + 1 < h) ? (rows[y+1] & m) : first_row;
                rows[y]  = next_gen_row(prev_row, cur, below, w);
                prev_row = cur;
            end
        endfunction

        // accepted input beat
        function void take_item(action_t act, logic [ROW_IDX_W-1:0] row,
                                logic [CELLS_W-1:0] cells);
            grid_result_t r;
            int h;
            logic [CELLS_W-1:0] m;
            h = eff_height();
            m = col_mask(eff_width());
            r.read_cells = '0;
            r.step_done  = 1'b0;
            case (act)
                ACT_WRITE: if (row < h) rows[row] = cells & m;
                ACT_READ:  if (row < h) r.read_cells = rows[row] & m;
                ACT_STEP:
                begin
                    advance_grid();
                    r.step_done = 1'b1;
                end
                default: ;
            endcase
            owed_results.push_back(r);
        endfunction

        // accepted output beat against the oldest owed result
        function void check_beat(logic [CELLS_W-1:0] cells, logic done);
            grid_result_t r;
            if (owed_results.size() == 0)
            begin
                $display("%0t: unexpected beat read_cells=%h step_done=%b",
                         $time, cells, done);
                errors++;
                return;
            end
            r = owed_results.pop_front();
            if (cells !== r.read_cells)
            begin
                $display("%0t: read_cells expected %h actual %h", $time, r.read_cells, cells);
                errors++;
            end
            if (done !== r.step_done)
            begin
                $display("%0t: step_done expected %b actual %b", $time, r.step_done, done);
                errors++;
            end
        endfunction

        function int pending();
            return owed_results.size();
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [71:0]          s_tdata;    // row_index, row_cells
    logic [ACT_W-1:0]     s_tuser;    // action
    logic                 m_tvalid;
    logic                 m_tready;
    logic [CELLS_W-1:0]   m_tdata;    // read_cells
    logic                 m_tuser;    // step_done
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    grid_tracker sb = new();
    int items_sent    = 0;
    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int hold_requests = 0;

    life_grid_generation_step_core #(
        .MAX_W(GRID_MAX_W),
        .MAX_H(GRID_MAX_H)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    initial
    begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

    // output side: random stalls plus the requested long hold-offs
    initial
    begin : result_sink
        int hold_left;
        int holds_done;
        hold_left  = 0;
        holds_done = 0;
        m_tready   = 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_done < hold_requests)
            begin
                holds_done++;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // check every accepted output beat
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_beat(m_tdata, m_tuser);
    end

    // random row contents of mixed density
    function automatic logic [CELLS_W-1:0] rand_cells();
        logic [CELLS_W-1:0] a;
        logic [CELLS_W-1:0] b;
        logic [CELLS_W-1:0] c;
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
        c = {$urandom, $urandom};
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2, 3:    return a;
            4, 5, 6: return a & b;
            default: return a & b & c;
        endcase
    endfunction

    // one input beat, with random gaps before it
    task automatic send_item(input action_t act, input logic [ROW_IDX_W-1:0] row,
                             input logic [CELLS_W-1:0] cells);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {2'b00, cells, row};
        do
            @(posedge clk);
        while (!s_tready);
        sb.take_item(act, row, cells);
        items_sent++;
    endtask

    // stop offering and wait for every owed result
    task automatic drain(input int settle);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // grid size registers, block idle
    task automatic set_grid(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IDX_WIDTH;
        cfg_data  <= w;
        @(posedge clk);
        sb.write_reg(CFG_IDX_WIDTH, w);
        cfg_index <= CFG_IDX_HEIGHT;
        cfg_data  <= h;
        @(posedge clk);
        sb.write_reg(CFG_IDX_HEIGHT, h);
        cfg_we <= 1'b0;
    endtask

    // fill the grid, run a few generations, read rows back
    task automatic run_life_sequence();
        int h;
        int rounds;
        h = sb.eff_height();
        for (int y = 0; y < h; y++)
            send_item(ACT_WRITE, 6'(y), rand_cells());
        rounds = $urandom_range(1, 4);
        repeat (rounds)
        begin
            send_item(ACT_STEP, 6'($urandom_range(63)), rand_cells());
            if ($urandom_range(3) == 0)
            begin
                for (int y = 0; y < h; y++)
                    send_item(ACT_READ, 6'(y), rand_cells());
            end
            else
                repeat ($urandom_range(1, 4))
                    send_item(ACT_READ, 6'($urandom_range(h - 1)), rand_cells());
        end
    endtask

    // main stimulus
    initial
    begin : stimulus
        logic [CFG_W-1:0] pw;
        logic [CFG_W-1:0] ph;
        int target;
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = ACT_WRITE;
        cfg_we    = 1'b0;
        cfg_index = CFG_IDX_WIDTH;
        cfg_data  = '0;
        tx_idle_pct = 7;
        rx_idle_pct = 46;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed beats on the reset grid size
        send_item(ACT_READ,  6'd0,  64'd0);
        send_item(ACT_WRITE, 6'd0,  '1);
        send_item(ACT_READ,  6'd0,  '1);
        send_item(ACT_WRITE, 6'd29, 64'hAAAA_AAAA_AAAA_AAAA);
        send_item(ACT_READ,  6'd29, 64'd0);
        // rows at or above the height
        send_item(ACT_WRITE, 6'd30, '1);
        send_item(ACT_READ,  6'd30, 64'd0);
        send_item(ACT_WRITE, 6'd63, '1);
        send_item(ACT_READ,  6'd63, '1);
        // unused action code
        send_item(ACT_NONE,  6'd5,  '1);
        // blinker
        send_item(ACT_WRITE, 6'd11, 64'h70);
        send_item(ACT_STEP,  6'd0,  64'd0);
        send_item(ACT_READ,  6'd0,  64'd0);
        send_item(ACT_READ,  6'd1,  64'd0);
        send_item(ACT_READ,  6'd10, 64'd0);
        send_item(ACT_READ,  6'd11, 64'd0);
        send_item(ACT_READ,  6'd12, 64'd0);
        send_item(ACT_READ,  6'd29, 64'd0);
        // pattern across the column wrap
        send_item(ACT_WRITE, 6'd0,  64'd0);
        send_item(ACT_WRITE, 6'd15, 64'h2000_0003);
        send_item(ACT_STEP,  6'd63, '1);
        send_item(ACT_READ,  6'd14, 64'd0);
        send_item(ACT_READ,  6'd15, 64'd0);
        send_item(ACT_READ,  6'd16, 64'd0);

        // random phases over several grid sizes
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain(8);
            if (p < 4)
            begin
                tx_idle_pct = 7;
                rx_idle_pct = 46;
            end
            else if (p < 8)
            begin
                tx_idle_pct = 46;
                rx_idle_pct = 7;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case (p)
                0:       begin pw = 7'd64;  ph = 7'd64;  end
                1:       begin pw = 7'd1;   ph = 7'd1;   end
                2:       begin pw = 7'd2;   ph = 7'd2;   end
                3:       begin pw = 7'd3;   ph = 7'd3;   end
                4:       begin pw = 7'd0;   ph = 7'd0;   end
                5:       begin pw = 7'd127; ph = 7'd127; end
                6:       begin pw = 7'd64;  ph = 7'd1;   end
                7:       begin pw = 7'd1;   ph = 7'd64;  end
                8:       begin pw = 7'd2;   ph = 7'd37;  end
                9:       begin pw = 7'd65;  ph = 7'd3;   end
                default:
                begin
                    pw = 7'($urandom_range(1, 64));
                    ph = 7'($urandom_range(1, 64));
                end
            endcase
            set_grid(pw, ph);
            if (p == 3 || p == 9)
                hold_requests++;
            target = items_sent + PHASE_ITEMS;
            while (items_sent < target)
            begin
                // sender pause until the block has handed back everything
                if (p == 6 && items_sent >= target - PHASE_ITEMS / 2
                        && items_sent < target - PHASE_ITEMS / 2 + 8)
                    drain(1);
                if ($urandom_range(9) < 7)
                    run_life_sequence();
                else
                    repeat ($urandom_range(1, 6))
                        send_item(action_t'($urandom_range(3)),
                                  6'($urandom_range(63)), rand_cells());
            end
        end

        // wrap up
        drain(100);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
